[design/sfd_pkg.sv]
`timescale 1ns / 1ps

package sfd_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BYTES  = 25;
  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned DATA_BYTES   = 22;
  localparam int unsigned CHAN_W       = 11;
  localparam int unsigned FRAME_W      = DATA_BYTES * 8;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned CH_W         = 4;

  // Widths of the configuration registers and of the config port
  localparam int unsigned SCALE_W  = 12;
  localparam int unsigned CENTER_W = 11;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 12;

  // Depth of the frame queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Special byte values
  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_0    = 8'h00;
  localparam logic [7:0] FOOTER_1    = 8'h04;
  localparam logic [7:0] FOOTER_2    = 8'h14;
  localparam logic [7:0] FOOTER_3    = 8'h24;
  localparam logic [7:0] FOOTER_4    = 8'h34;

  // Configuration reset values
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 12'd659;
  localparam logic [CENTER_W-1:0] CENTER_RESET = 11'd1024;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd1500;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd10;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE  = 8'd0,
    REG_CENTER = 8'd1,
    REG_OFFSET = 8'd2,
    REG_COUNT  = 8'd3
  } cfg_reg_e;

  // Channel payload of one frame, byte 1 in the low bits
  typedef logic [FRAME_W-1:0] frame_t;

  // Live configuration seen by the back part
  typedef struct packed {
    logic [SCALE_W-1:0]  scale_q10;
    logic [CENTER_W-1:0] center_value;
    logic [OFFSET_W-1:0] offset_value;
    logic [COUNT_W-1:0]  scaled_channel_count;
  } cfg_t;

  // Push side of the frame queue
  typedef struct packed {
    logic   push;
    frame_t data;
  } q_push_t;

  // Head of the frame queue as seen by the back part
  typedef struct packed {
    logic   empty;
    logic   full;
    frame_t head;
  } q_status_t;

  function automatic logic footer_ok(input logic [7:0] b);
    return (b == FOOTER_0) || (b == FOOTER_1) || (b == FOOTER_2) ||
           (b == FOOTER_3) || (b == FOOTER_4);
  endfunction

endpackage

[design/sfd_byte_if.sv]
`timescale 1ns / 1ps

interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/sfd_result_if.sv]
`timescale 1ns / 1ps

interface sfd_result_if;
  logic                            valid;
  logic                            ready;
  logic [sfd_pkg::CH_W-1:0]        channel_index;
  logic [sfd_pkg::CHAN_W-1:0]      raw_value;
  logic signed [15:0]              scaled_value;
  logic                            scaled_valid;
  logic                            last_channel;

  modport source (output valid, output channel_index, output raw_value,
                  output scaled_value, output scaled_valid, output last_channel,
                  input ready);
  modport sink   (input valid, input channel_index, input raw_value,
                  input scaled_value, input scaled_valid, input last_channel,
                  output ready);
endinterface

[design/sfd_cfg_if.sv]
`timescale 1ns / 1ps

interface sfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sfd_pkg::CFG_IDX_W-1:0]     index;
  logic [sfd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/sfd_front.sv]
`timescale 1ns / 1ps

module sfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sfd_byte_if.sink             rx,
  input  logic                 q_full_i,
  output sfd_pkg::q_push_t     q_push_o
);

  logic [sfd_pkg::POS_W-1:0] pos_q, pos_d;
  sfd_pkg::frame_t           data_q;
  logic [sfd_pkg::POS_W-1:0] slot;
  logic                      at_footer;
  logic                      beat;

  // The footer beat waits while the queue has no room for the frame.
  assign at_footer = (pos_q == sfd_pkg::POS_W'(sfd_pkg::FRAME_BYTES - 1));
  assign rx.ready  = !(at_footer && q_full_i);
  assign beat      = rx.valid && rx.ready;
  assign slot      = pos_q - sfd_pkg::POS_W'(1);

  // Frame position: zero is idle, waiting for a header byte.
  always_comb begin
    pos_d = pos_q;
    if (beat) begin
      if (pos_q == '0) begin
        if (rx.rx_byte == sfd_pkg::HEADER_BYTE) begin
          pos_d = sfd_pkg::POS_W'(1);
        end
      end else if (at_footer) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + sfd_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Channel bytes land in fixed slots; the flags byte is not kept.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sfd_pkg::DATA_BYTES; i++) begin
      if (beat && pos_q != '0 && slot == sfd_pkg::POS_W'(i)) begin
        data_q[i*8 +: 8] <= rx.rx_byte;
      end
    end
  end

  // A complete frame with a good footer goes to the queue.
  always_comb begin
    q_push_o.push = beat && at_footer && sfd_pkg::footer_ok(rx.rx_byte);
    q_push_o.data = data_q;
  end

endmodule

[design/sfd_queue.sv]
`timescale 1ns / 1ps

module sfd_queue #(
  parameter int unsigned DEPTH = sfd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfd_pkg::q_push_t     push_i,
  input  logic                 pop_i,
  output sfd_pkg::q_status_t   status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sfd_pkg::frame_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign do_push = push_i.push && (count_q != CNT_W'(DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Frame storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.data;
  end

  always_comb begin
    status_o.empty = (count_q == '0);
    status_o.full  = (count_q == CNT_W'(DEPTH));
    status_o.head  = mem_q[rd_ptr_q];
  end

endmodule

[design/sfd_back.sv]
`timescale 1ns / 1ps

module sfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfd_pkg::cfg_t        cfg_i,
  input  sfd_pkg::q_status_t   q_status_i,
  output logic                 q_pop_o,
  sfd_result_if.source         res
);

  localparam int unsigned PROD_W = sfd_pkg::SCALE_W + 1 + sfd_pkg::CENTER_W + 1;
  localparam int unsigned Q_W    = PROD_W - 10;
  localparam int unsigned SUM_W  = 18;

  logic [sfd_pkg::CH_W-1:0]   ch_q;
  logic                       advance, issue;
  logic [sfd_pkg::CHAN_W-1:0] raw_sel;

  // Stage 1: unpacked channel and offset from center
  logic                       s1_valid_q;
  logic [sfd_pkg::CH_W-1:0]   s1_ch_q;
  logic [sfd_pkg::CHAN_W-1:0] s1_raw_q;
  logic signed [sfd_pkg::CENTER_W:0] s1_diff_q;
  logic                       s1_sv_q;

  // Stage 2: product with the gain
  logic                       s2_valid_q;
  logic [sfd_pkg::CH_W-1:0]   s2_ch_q;
  logic [sfd_pkg::CHAN_W-1:0] s2_raw_q;
  logic signed [PROD_W-1:0]   s2_prod_q;
  logic                       s2_sv_q;

  // Output register
  logic                       out_valid_q;
  logic [sfd_pkg::CH_W-1:0]   out_ch_q;
  logic [sfd_pkg::CHAN_W-1:0] out_raw_q;
  logic signed [15:0]         out_scaled_q;
  logic                       out_sv_q;

  logic signed [Q_W-1:0]      quot;
  logic signed [SUM_W-1:0]    sum;
  logic signed [15:0]         sat;

  // The whole pipeline moves together whenever the output slot frees up.
  assign advance = !out_valid_q || res.ready;
  assign issue   = advance && !q_status_i.empty;
  assign q_pop_o = issue && (ch_q == sfd_pkg::CH_W'(sfd_pkg::NUM_CHANNELS - 1));

  // Pick the 11-bit field of the current channel.
  always_comb begin
    raw_sel = '0;
    for (int c = 0; c < sfd_pkg::NUM_CHANNELS; c++) begin
      if (ch_q == sfd_pkg::CH_W'(c)) begin
        raw_sel = q_status_i.head[c*sfd_pkg::CHAN_W +: sfd_pkg::CHAN_W];
      end
    end
  end

  // Floor shift, offset and clamp to signed 16 bits.
  always_comb begin
    quot = s2_prod_q[PROD_W-1:10];
    sum  = SUM_W'(quot) + $signed({{(SUM_W - sfd_pkg::OFFSET_W){1'b0}}, cfg_i.offset_value});
    if (sum > SUM_W'(32767)) begin
      sat = 16'sd32767;
    end else if (sum < -SUM_W'(32768)) begin
      sat = -16'sd32768;
    end else begin
      sat = sum[15:0];
    end
  end

  // Control: channel counter and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      if (issue) ch_q <= ch_q + sfd_pkg::CH_W'(1);
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_ch_q   <= ch_q;
      s1_raw_q  <= raw_sel;
      s1_diff_q <= $signed({1'b0, raw_sel}) - $signed({1'b0, cfg_i.center_value});
      s1_sv_q   <= {1'b0, ch_q} < cfg_i.scaled_channel_count;

      s2_ch_q   <= s1_ch_q;
      s2_raw_q  <= s1_raw_q;
      s2_prod_q <= PROD_W'(s1_diff_q * $signed({1'b0, cfg_i.scale_q10}));
      s2_sv_q   <= s1_sv_q;

      out_ch_q     <= s2_ch_q;
      out_raw_q    <= s2_raw_q;
      out_scaled_q <= s2_sv_q ? sat : 16'sd0;
      out_sv_q     <= s2_sv_q;
    end
  end

  assign res.valid         = out_valid_q;
  assign res.channel_index = out_ch_q;
  assign res.raw_value     = out_raw_q;
  assign res.scaled_value  = out_scaled_q;
  assign res.scaled_valid  = out_sv_q;
  assign res.last_channel  = (out_ch_q == sfd_pkg::CH_W'(sfd_pkg::NUM_CHANNELS - 1));

endmodule

[design/sbus_frame_decoder.sv]
`timescale 1ns / 1ps

// Takes one byte per cycle; a header byte plus 24 more make a frame.
// A good frame gives 16 channel beats; the first comes out once the frame has passed the queue
// and the three-stage unpack/multiply/clamp pipeline, then one per cycle while res_o.ready does not stall it.
// A full frame queue holds back only the footer beat of the next frame.
// Reset (rst_ni low, asynchronous) empties the queue and pipeline, returns to idle
// and loads the default gain, center, offset and scaled channel count.
module sbus_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfd_byte_if.sink     rx_i,
  sfd_cfg_if.sink      cfg_i,
  sfd_result_if.source res_o
);

  sfd_pkg::cfg_t      cfg_q;
  sfd_pkg::q_push_t   q_push;
  sfd_pkg::q_status_t q_status;
  logic               q_pop;
  sfd_pkg::cfg_reg_e  cfg_idx;

  // Configuration registers, always ready
  assign cfg_i.ready = 1'b1;
  assign cfg_idx     = sfd_pkg::cfg_reg_e'(cfg_i.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_q10            <= sfd_pkg::SCALE_RESET;
      cfg_q.center_value         <= sfd_pkg::CENTER_RESET;
      cfg_q.offset_value         <= sfd_pkg::OFFSET_RESET;
      cfg_q.scaled_channel_count <= sfd_pkg::COUNT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx)
        sfd_pkg::REG_SCALE:  cfg_q.scale_q10    <= cfg_i.data[sfd_pkg::SCALE_W-1:0];
        sfd_pkg::REG_CENTER: cfg_q.center_value <= cfg_i.data[sfd_pkg::CENTER_W-1:0];
        sfd_pkg::REG_OFFSET: cfg_q.offset_value <= cfg_i.data[sfd_pkg::OFFSET_W-1:0];
        sfd_pkg::REG_COUNT: begin
          cfg_q.scaled_channel_count <= cfg_i.data[sfd_pkg::COUNT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  sfd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx       (rx_i),
    .q_full_i (q_status.full),
    .q_push_o (q_push)
  );

  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .pop_i    (q_pop),
    .status_o (q_status)
  );

  sfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_status_i (q_status),
    .q_pop_o    (q_pop),
    .res        (res_o)
  );

  // A frame is never pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.push |-> !q_status.full)
    else $error("frame pushed into full queue");

  // The back part never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // An unscaled channel carries a zero scaled value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.scaled_valid) |-> (res_o.scaled_value == 16'sd0))
    else $error("nonzero scaled value on unscaled channel");

  // A delivered channel other than the last is followed by the next channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.last_channel) ##1 res_o.valid |->
      (res_o.channel_index == $past(res_o.channel_index) + 4'd1))
    else $error("channel order broken");

endmodule
